@@ rtl/ihex_pkg.sv @@
package ihex_pkg;

	// Character classes produced by the front end
	typedef logic [1:0] char_cls_t;
	localparam char_cls_t CLS_SKIP  = 2'd0;  // printable or whitespace, not hex, not colon
	localparam char_cls_t CLS_HEX   = 2'd1;  // hex digit of either case
	localparam char_cls_t CLS_COLON = 2'd2;  // record start mark
	localparam char_cls_t CLS_BAD   = 2'd3;  // control or high code, never allowed

	typedef struct packed {
		char_cls_t  cls;
		logic [3:0] nib;
	} token_t;

	// Parser phases
	localparam logic [2:0] PH_HUNT = 3'd0;
	localparam logic [2:0] PH_LEN  = 3'd1;
	localparam logic [2:0] PH_ADDR = 3'd2;
	localparam logic [2:0] PH_TYPE = 3'd3;
	localparam logic [2:0] PH_DATA = 3'd4;

	// Result kinds and record status codes
	localparam logic       KIND_DATA  = 1'b0;
	localparam logic       KIND_END   = 1'b1;
	localparam logic [1:0] ST_DATA    = 2'd0;
	localparam logic [1:0] ST_END     = 2'd1;
	localparam logic [1:0] ST_BADFMT  = 2'd2;
	localparam logic [1:0] ST_BADSUM  = 2'd3;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_FF    = 8'h0C;

	function automatic token_t classify(input logic [7:0] c);
		token_t t;
		logic [7:0] v;
		t.nib = 4'd0;
		v = 8'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			t.cls = CLS_HEX;
			v = c - 8'h30;
		end else if (c >= 8'h41 && c <= 8'h46) begin
			t.cls = CLS_HEX;
			v = c - 8'h37;
		end else if (c >= 8'h61 && c <= 8'h66) begin
			t.cls = CLS_HEX;
			v = c - 8'h57;
		end else if (c == CH_COLON) begin
			t.cls = CLS_COLON;
		end else if ((c >= 8'h20 && c <= 8'h7E) || c == CH_CR || c == CH_LF
				|| c == CH_TAB || c == CH_FF) begin
			t.cls = CLS_SKIP;
		end else begin
			t.cls = CLS_BAD;
		end
		t.nib = v[3:0];
		return t;
	endfunction

endpackage

@@ rtl/ihex_front.sv @@
module ihex_front import ihex_pkg::*; (
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_in,
	output logic       push,
	output token_t     push_token,
	input  logic       queue_full
);

	// Classify each character and hand it to the queue
	assign in_stall   = queue_full;
	assign push       = in_valid & ~queue_full;
	assign push_token = classify(char_in);

endmodule

@@ rtl/ihex_queue.sv @@
module ihex_queue import ihex_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  token_t push_token,
	output logic   full,
	output logic   pop_valid,
	output token_t pop_token,
	input  logic   pop
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	token_t             entry_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_token = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_token;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/ihex_back.sv @@
module ihex_back import ihex_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        tok_valid,
	input  token_t      tok,
	output logic        tok_pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        event_kind,
	output logic [7:0]  data_byte,
	output logic [7:0]  byte_index,
	output logic [15:0] record_address,
	output logic        record_type,
	output logic [7:0]  record_length,
	output logic [1:0]  record_status
);

	logic [2:0]  phase_q;
	logic [3:0]  high_q;
	logic        pending_q;
	logic        addr_lo_q;
	logic [7:0]  length_q;
	logic [15:0] address_q;
	logic        type_q;
	logic [7:0]  seen_q;
	logic [7:0]  sum_q;
	logic        out_valid_q;

	logic [2:0]  phase_d;
	logic [3:0]  high_d;
	logic        pending_d;
	logic        addr_lo_d;
	logic [7:0]  length_d;
	logic [15:0] address_d;
	logic        type_d;
	logic [7:0]  seen_d;
	logic [7:0]  sum_d;

	logic        produce;
	logic        res_kind;
	logic [7:0]  res_data;
	logic [7:0]  res_index;
	logic [1:0]  res_status;
	logic        clear;
	logic [7:0]  byte_val;
	logic [7:0]  sum_next;
	logic        can_out;
	logic        load;

	assign byte_val = {high_q, tok.nib};
	assign sum_next = sum_q + byte_val;
	assign can_out  = ~out_valid_q | ~out_stall;
	assign tok_pop  = tok_valid & (~produce | can_out);
	assign load     = tok_pop & produce;

	always_comb begin
		phase_d    = phase_q;
		high_d     = high_q;
		pending_d  = pending_q;
		addr_lo_d  = addr_lo_q;
		length_d   = length_q;
		address_d  = address_q;
		type_d     = type_q;
		seen_d     = seen_q;
		sum_d      = sum_q;
		produce    = 1'b0;
		clear      = 1'b0;
		res_kind   = KIND_END;
		res_data   = 8'd0;
		res_index  = 8'd0;
		res_status = ST_BADFMT;

		if (phase_q == PH_HUNT) begin
			unique case (tok.cls)
				CLS_COLON: begin
					clear   = 1'b1;
					phase_d = PH_LEN;
				end
				CLS_BAD: begin
					produce = 1'b1;
					clear   = 1'b1;
				end
				default: ;
			endcase
		end else if (tok.cls != CLS_HEX) begin
			produce = 1'b1;
			clear   = 1'b1;
		end else if (!pending_q) begin
			high_d    = tok.nib;
			pending_d = 1'b1;
		end else begin
			pending_d = 1'b0;
			sum_d     = sum_next;
			unique case (phase_q)
				PH_LEN: begin
					length_d  = byte_val;
					addr_lo_d = 1'b0;
					phase_d   = PH_ADDR;
				end
				PH_ADDR: begin
					if (!addr_lo_q) begin
						address_d = {byte_val, 8'd0};
						addr_lo_d = 1'b1;
					end else begin
						address_d = {address_q[15:8], byte_val};
						addr_lo_d = 1'b0;
						phase_d   = PH_TYPE;
					end
				end
				PH_TYPE: begin
					if (byte_val > 8'd1) begin
						produce = 1'b1;
						clear   = 1'b1;
					end else begin
						type_d  = byte_val[0];
						seen_d  = 8'd0;
						phase_d = PH_DATA;
					end
				end
				default: begin
					produce = 1'b1;
					if (seen_q < length_q) begin
						res_kind   = KIND_DATA;
						res_data   = byte_val;
						res_index  = seen_q;
						res_status = ST_DATA;
						seen_d     = seen_q + 1'b1;
					end else begin
						clear = 1'b1;
						if (sum_next != 8'd0) begin
							res_status = ST_BADSUM;
						end else begin
							res_status = type_q ? ST_END : ST_DATA;
						end
					end
				end
			endcase
		end

		// Drop back to a clean header after a finished or malformed record or at a colon;
		// a finished record always goes back to hunting
		if (clear) begin
			high_d    = 4'd0;
			pending_d = 1'b0;
			addr_lo_d = 1'b0;
			length_d  = 8'd0;
			address_d = 16'd0;
			type_d    = 1'b0;
			seen_d    = 8'd0;
			sum_d     = 8'd0;
			if (produce) begin
				phase_d = PH_HUNT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			high_q      <= 4'd0;
			pending_q   <= 1'b0;
			addr_lo_q   <= 1'b0;
			length_q    <= 8'd0;
			address_q   <= 16'd0;
			type_q      <= 1'b0;
			seen_q      <= 8'd0;
			sum_q       <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (tok_pop) begin
				phase_q   <= phase_d;
				high_q    <= high_d;
				pending_q <= pending_d;
				addr_lo_q <= addr_lo_d;
				length_q  <= length_d;
				address_q <= address_d;
				type_q    <= type_d;
				seen_q    <= seen_d;
				sum_q     <= sum_d;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result register: header fields are those in force before this token
	always_ff @(posedge clk) begin
		if (load) begin
			event_kind     <= res_kind;
			data_byte      <= res_data;
			byte_index     <= res_index;
			record_address <= address_q;
			record_type    <= type_q;
			record_length  <= length_q;
			record_status  <= res_status;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ rtl/intel_hex_record_parser_core.sv @@
// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_stall    char_in
// output    out        out_valid / out_stall  event_kind, data_byte, byte_index,
//                                             record_address, record_type,
//                                             record_length, record_status
//
// One character is taken per cycle, back to back, while in_stall is low. A
// character enters the queue at its transfer edge; its result, if any, loads
// the result register at the next edge at the earliest, setting out_valid too.
// arst_n clears the queue, parser phase, header registers and out_valid.
// A stalled output holds the back end only on a result-bearing token;
// in_stall rises once QUEUE_DEPTH characters wait in the queue.
module intel_hex_record_parser_core import ihex_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        event_kind,
	output logic [7:0]  data_byte,
	output logic [7:0]  byte_index,
	output logic [15:0] record_address,
	output logic        record_type,
	output logic [7:0]  record_length,
	output logic [1:0]  record_status
);

	logic   push;
	token_t push_token;
	logic   queue_full;
	logic   tok_valid;
	token_t tok;
	logic   tok_pop;

	// Front end: classify each transfer into colon, hex digit, skip or bad
	ihex_front u_front (
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.char_in    (char_in),
		.push       (push),
		.push_token (push_token),
		.queue_full (queue_full)
	);

	// Token queue decouples input stalls from output stalls
	ihex_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_token (push_token),
		.full       (queue_full),
		.pop_valid  (tok_valid),
		.pop_token  (tok),
		.pop        (tok_pop)
	);

	// Back end: record state machine, running checksum and result register
	ihex_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.tok_valid      (tok_valid),
		.tok            (tok),
		.tok_pop        (tok_pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.event_kind     (event_kind),
		.data_byte      (data_byte),
		.byte_index     (byte_index),
		.record_address (record_address),
		.record_type    (record_type),
		.record_length  (record_length),
		.record_status  (record_status)
	);

endmodule
